// ===== rtl/core/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

  localparam int unsigned CH_W   = 21;
  localparam int unsigned CP_W   = 32;
  localparam int unsigned HEX_W  = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ERR_W  = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_UNTERM    = 3'd1,
    ERR_CONTROL   = 3'd2,
    ERR_ESCAPE    = 3'd3,
    ERR_BAD_HEX   = 3'd4,
    ERR_SHORT_U   = 3'd5,
    ERR_SURROGATE = 3'd6
  } err_e;

  localparam logic [CH_W-1:0] CH_QUOTE  = 21'h22;
  localparam logic [CH_W-1:0] CH_BSLASH = 21'h5C;
  localparam logic [CH_W-1:0] CH_SLASH  = 21'h2F;
  localparam logic [CH_W-1:0] CH_LOW_B  = 21'h62;
  localparam logic [CH_W-1:0] CH_LOW_F  = 21'h66;
  localparam logic [CH_W-1:0] CH_LOW_N  = 21'h6E;
  localparam logic [CH_W-1:0] CH_LOW_R  = 21'h72;
  localparam logic [CH_W-1:0] CH_LOW_T  = 21'h74;
  localparam logic [CH_W-1:0] CH_LOW_U  = 21'h75;

  localparam logic [CP_W-1:0] CP_BS  = 32'h08;
  localparam logic [CP_W-1:0] CP_FF  = 32'h0C;
  localparam logic [CP_W-1:0] CP_LF  = 32'h0A;
  localparam logic [CP_W-1:0] CP_CR  = 32'h0D;
  localparam logic [CP_W-1:0] CP_TAB = 32'h09;

  localparam logic [HEX_W-1:0] HIGH_MIN      = 16'hD800;
  localparam logic [HEX_W-1:0] HIGH_MAX      = 16'hDBFF;
  localparam logic [CP_W-1:0]  LOW_BASE      = 32'h0000DC00;
  localparam logic [CP_W-1:0]  SUPP_BASE     = 32'h00010000;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } hex_t;

  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [CP_W-1:0] code_point;
    err_e            err;
  } result_t;

  function automatic hex_t hex_digit(input logic [CH_W-1:0] c);
    hex_t h;
    h.ok    = 1'b0;
    h.digit = c[3:0];
    if (c >= 21'h30 && c <= 21'h39) begin
      h.ok = 1'b1;
    end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
      h.ok    = 1'b1;
      h.digit = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jsu_if.sv =====
`default_nettype none

interface jsu_in_if;
  logic                      valid;
  logic                      ready;
  logic [jsu_pkg::CH_W-1:0]  ch;
  logic                      end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic                        valid;
  logic                        ready;
  logic [jsu_pkg::KIND_W-1:0]  kind;
  logic [jsu_pkg::CP_W-1:0]    code_point;
  logic [jsu_pkg::ERR_W-1:0]   error_code;

  modport source (output valid, output kind, output code_point, output error_code,
                  input ready);
  modport sink   (input valid, input kind, input code_point, input error_code,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/jsu_decode.sv =====
`default_nettype none

module jsu_decode (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     step_i,
  input  wire logic [jsu_pkg::CH_W-1:0] ch_i,
  input  wire logic                     eot_i,
  output jsu_pkg::result_t              res_o
);

  typedef enum logic [2:0] {
    PH_NORMAL  = 3'd0,
    PH_ESCAPE  = 3'd1,
    PH_HEX1    = 3'd2,
    PH_WANT_BS = 3'd3,
    PH_WANT_U  = 3'd4,
    PH_HEX2    = 3'd5
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [jsu_pkg::HEX_W-1:0]       hex_q, hex_d;
  logic [1:0]                      cnt_q, cnt_d;
  logic [jsu_pkg::HEX_W-1:0]       high_q, high_d;

  jsu_pkg::hex_t                   hx;
  logic [jsu_pkg::HEX_W-1:0]       hex_next;
  logic [jsu_pkg::CP_W-1:0]        merged;
  logic                            clear;
  logic                            fail;
  jsu_pkg::err_e                   fail_code;

  always_comb begin
    hx       = jsu_pkg::hex_digit(ch_i);
    hex_next = {hex_q[jsu_pkg::HEX_W-5:0], hx.digit};
    merged   = jsu_pkg::CP_W'({high_q[9:0], 10'b0}) + jsu_pkg::CP_W'(hex_next)
               - jsu_pkg::LOW_BASE + jsu_pkg::SUPP_BASE;

    phase_d   = phase_q;
    hex_d     = hex_q;
    cnt_d     = cnt_q;
    high_d    = high_q;
    clear     = 1'b0;
    fail      = 1'b0;
    fail_code = jsu_pkg::ERR_NONE;
    res_o     = '{valid: 1'b0, kind: jsu_pkg::KIND_CHAR, code_point: '0,
                  err: jsu_pkg::ERR_NONE};

    if (eot_i) begin
      fail      = 1'b1;
      fail_code = jsu_pkg::ERR_UNTERM;
    end else if (ch_i[jsu_pkg::CH_W-1:5] == '0) begin
      fail      = 1'b1;
      fail_code = jsu_pkg::ERR_CONTROL;
    end else begin
      unique case (phase_q)
        PH_NORMAL: begin
          if (ch_i == jsu_pkg::CH_BSLASH) begin
            phase_d = PH_ESCAPE;
          end else if (ch_i == jsu_pkg::CH_QUOTE) begin
            clear       = 1'b1;
            res_o.valid = 1'b1;
            res_o.kind  = jsu_pkg::KIND_CLOSE;
          end else begin
            res_o.valid      = 1'b1;
            res_o.code_point = jsu_pkg::CP_W'(ch_i);
          end
        end
        PH_ESCAPE: begin
          phase_d     = PH_NORMAL;
          res_o.valid = 1'b1;
          unique case (ch_i) inside
            jsu_pkg::CH_BSLASH, jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH:
              res_o.code_point = jsu_pkg::CP_W'(ch_i);
            jsu_pkg::CH_LOW_B: res_o.code_point = jsu_pkg::CP_BS;
            jsu_pkg::CH_LOW_F: res_o.code_point = jsu_pkg::CP_FF;
            jsu_pkg::CH_LOW_N: res_o.code_point = jsu_pkg::CP_LF;
            jsu_pkg::CH_LOW_R: res_o.code_point = jsu_pkg::CP_CR;
            jsu_pkg::CH_LOW_T: res_o.code_point = jsu_pkg::CP_TAB;
            jsu_pkg::CH_LOW_U: begin
              res_o.valid = 1'b0;
              phase_d     = PH_HEX1;
              hex_d       = '0;
              cnt_d       = '0;
            end
            default: begin
              res_o.valid = 1'b0;
              fail        = 1'b1;
              fail_code   = jsu_pkg::ERR_ESCAPE;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (ch_i == jsu_pkg::CH_QUOTE) begin
            fail      = 1'b1;
            fail_code = (phase_q == PH_HEX1) ? jsu_pkg::ERR_SHORT_U : jsu_pkg::ERR_SURROGATE;
          end else if (!hx.ok) begin
            fail      = 1'b1;
            fail_code = jsu_pkg::ERR_BAD_HEX;
          end else if (cnt_q != 2'd3) begin
            hex_d = hex_next;
            cnt_d = cnt_q + 2'd1;
          end else if (phase_q == PH_HEX1 &&
                       hex_next >= jsu_pkg::HIGH_MIN && hex_next <= jsu_pkg::HIGH_MAX) begin
            // hold the high half until the low escape arrives
            high_d  = hex_next;
            hex_d   = '0;
            cnt_d   = '0;
            phase_d = PH_WANT_BS;
          end else begin
            clear            = 1'b1;
            res_o.valid      = 1'b1;
            res_o.code_point = (phase_q == PH_HEX1) ? jsu_pkg::CP_W'(hex_next) : merged;
          end
        end
        PH_WANT_BS: begin
          if (ch_i == jsu_pkg::CH_BSLASH) begin
            phase_d = PH_WANT_U;
          end else begin
            fail      = 1'b1;
            fail_code = jsu_pkg::ERR_SURROGATE;
          end
        end
        PH_WANT_U: begin
          if (ch_i == jsu_pkg::CH_LOW_U) begin
            phase_d = PH_HEX2;
            hex_d   = '0;
            cnt_d   = '0;
          end else begin
            fail      = 1'b1;
            fail_code = jsu_pkg::ERR_SURROGATE;
          end
        end
        default: clear = 1'b1;
      endcase
    end

    if (fail) begin
      clear       = 1'b1;
      res_o.valid = 1'b1;
      res_o.kind  = jsu_pkg::KIND_ERROR;
      res_o.err   = fail_code;
    end

    if (clear) begin
      phase_d = PH_NORMAL;
      hex_d   = '0;
      cnt_d   = '0;
      high_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      hex_q   <= '0;
      cnt_q   <= '0;
      high_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      cnt_q   <= cnt_d;
      high_q  <= high_d;
    end
  end

  a_close_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.kind != jsu_pkg::KIND_CHAR
      |=> phase_q == PH_NORMAL && cnt_q == 2'd0 && high_q == '0)
    else $error("state not cleared after close or error");

  a_count_in_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd0 |-> phase_q == PH_HEX1 || phase_q == PH_HEX2)
    else $error("digit count outside a hex group");

  a_high_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WANT_BS || phase_q == PH_WANT_U
      |-> high_q >= jsu_pkg::HIGH_MIN && high_q <= jsu_pkg::HIGH_MAX)
    else $error("low half expected without a high surrogate");

endmodule

`default_nettype wire

// ===== rtl/core/json_string_unescape.sv =====
// JSON string body decoder. Feed the characters after the opening quote, one code
// point per beat; each beat yields at most one result: a decoded character, a
// string-closed marker or an error, after which the block is ready for the next
// string body. Throughput is one beat per cycle while the output is not stalled;
// a result passes through the input register, the escape and surrogate state
// update in the decoder, and the result register. Beats that only advance an
// escape (backslash, u, hex digits, high surrogate) give no result.
`default_nettype none

module json_string_unescape (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jsu_in_if.sink     in_i,
  jsu_out_if.source  out_o
);

  logic                     s1_valid_q;
  logic [jsu_pkg::CH_W-1:0] s1_ch_q;
  logic                     s1_eot_q;
  logic                     out_valid_q;
  jsu_pkg::result_t         out_q;
  jsu_pkg::result_t         res;
  logic                     out_free;
  logic                     step;

  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ch_i   (s1_ch_q),
    .eot_i  (s1_eot_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (out_free) out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q  <= in_i.ch;
      s1_eot_q <= in_i.end_of_text;
    end
    if (step) out_q <= res;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.code_point = out_q.code_point;
  assign out_o.error_code = out_q.err;

  a_error_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == jsu_pkg::KIND_ERROR
      |-> out_q.code_point == '0 && out_q.err != jsu_pkg::ERR_NONE)
    else $error("error beat carries a code point or no error code");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_ch_q) && $stable(s1_eot_q))
    else $error("input stage dropped while the result was stalled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_q))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ===== tb/json_string_unescape_tb.sv =====
`timescale 1ns / 1ps

module json_string_unescape_tb;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BEATS_PER_MIX = 175;
  localparam int HOLD_CYCLES = 160;

  typedef enum logic [2:0] {
    SCAN_TEXT,
    SCAN_ESCAPE,
    SCAN_HEX_HIGH,
    SCAN_WANT_BSLASH,
    SCAN_WANT_U,
    SCAN_HEX_LOW
  } scan_phase_e;

  typedef struct packed {
    kind_e           kind;
    logic [CP_W-1:0] cp;
    err_e            err;
  } decoded_t;

  class unescape_scoreboard;
    scan_phase_e      phase;
    logic [HEX_W-1:0] hex_acc;
    logic [1:0]       digits;
    logic [HEX_W-1:0] high_half;
    decoded_t         expected_q[$];
    int               beats, chars, closes, faults, mismatches;
    bit [7:0]         codes_seen;

    function new();
      clear_scan();
      beats = 0;
      chars = 0;
      closes = 0;
      faults = 0;
      mismatches = 0;
      codes_seen = '0;
    endfunction

    function void clear_scan();
      phase = SCAN_TEXT;
      hex_acc = '0;
      digits = '0;
      high_half = '0;
    endfunction

    function int nibble_of(logic [CH_W-1:0] c);
      if (c >= 21'h30 && c <= 21'h39) return int'(c - 21'h30);
      if (c >= 21'h61 && c <= 21'h66) return int'(c - 21'h61) + 10;
      if (c >= 21'h41 && c <= 21'h46) return int'(c - 21'h41) + 10;
      return -1;
    endfunction

    function void abort(err_e e, output decoded_t r);
      clear_scan();
      r.kind = KIND_ERROR;
      r.cp = '0;
      r.err = e;
    endfunction

    // Advance the decoder by one beat; return 1 when the beat yields a result.
    function bit decode_step(logic [CH_W-1:0] c, logic eot, output decoded_t r);
      int d;
      r.kind = KIND_CHAR;
      r.cp = '0;
      r.err = ERR_NONE;
      if (eot) begin
        abort(ERR_UNTERM, r);
        return 1'b1;
      end
      if (c < 21'h20) begin
        abort(ERR_CONTROL, r);
        return 1'b1;
      end
      case (phase)
        SCAN_TEXT: begin
          if (c == CH_BSLASH) begin
            phase = SCAN_ESCAPE;
            return 1'b0;
          end
          if (c == CH_QUOTE) begin
            clear_scan();
            r.kind = KIND_CLOSE;
            return 1'b1;
          end
          r.cp = CP_W'(c);
          return 1'b1;
        end
        SCAN_ESCAPE: begin
          phase = SCAN_TEXT;
          case (c)
            CH_BSLASH, CH_QUOTE, CH_SLASH: r.cp = CP_W'(c);
            CH_LOW_B: r.cp = CP_BS;
            CH_LOW_F: r.cp = CP_FF;
            CH_LOW_N: r.cp = CP_LF;
            CH_LOW_R: r.cp = CP_CR;
            CH_LOW_T: r.cp = CP_TAB;
            CH_LOW_U: begin
              phase = SCAN_HEX_HIGH;
              hex_acc = '0;
              digits = '0;
              return 1'b0;
            end
            default: abort(ERR_ESCAPE, r);
          endcase
          return 1'b1;
        end
        SCAN_HEX_HIGH, SCAN_HEX_LOW: begin
          if (c == CH_QUOTE) begin
            abort(phase == SCAN_HEX_HIGH ? ERR_SHORT_U : ERR_SURROGATE, r);
            return 1'b1;
          end
          d = nibble_of(c);
          if (d < 0) begin
            abort(ERR_BAD_HEX, r);
            return 1'b1;
          end
          hex_acc = {hex_acc[11:0], 4'(d)};
          if (digits != 2'd3) begin
            digits = digits + 2'd1;
            return 1'b0;
          end
          digits = '0;
          if (phase == SCAN_HEX_HIGH) begin
            if (hex_acc >= HIGH_MIN && hex_acc <= HIGH_MAX) begin
              // hold the high half until the low escape arrives
              high_half = hex_acc;
              hex_acc = '0;
              phase = SCAN_WANT_BSLASH;
              return 1'b0;
            end
            r.cp = CP_W'(hex_acc);
          end else begin
            r.cp = (CP_W'(high_half[9:0]) << 10) + CP_W'(hex_acc) - LOW_BASE + SUPP_BASE;
          end
          clear_scan();
          return 1'b1;
        end
        SCAN_WANT_BSLASH: begin
          if (c != CH_BSLASH) begin
            abort(ERR_SURROGATE, r);
            return 1'b1;
          end
          phase = SCAN_WANT_U;
          return 1'b0;
        end
        SCAN_WANT_U: begin
          if (c != CH_LOW_U) begin
            abort(ERR_SURROGATE, r);
            return 1'b1;
          end
          phase = SCAN_HEX_LOW;
          hex_acc = '0;
          digits = '0;
          return 1'b0;
        end
        default: begin
          clear_scan();
          return 1'b0;
        end
      endcase
    endfunction

    function void note_input(logic [CH_W-1:0] c, logic eot);
      decoded_t r;
      beats++;
      if (decode_step(c, eot, r)) expected_q.push_back(r);
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [CP_W-1:0] cp,
                               logic [ERR_W-1:0] err);
      decoded_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d cp=%h err=%0d", kind, cp, err);
        return;
      end
      e = expected_q.pop_front();
      case (e.kind)
        KIND_CHAR:  chars++;
        KIND_CLOSE: closes++;
        default:    faults++;
      endcase
      codes_seen[e.err] = 1'b1;
      if (kind !== e.kind || cp !== e.cp || err !== e.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind=%0d cp=%h err=%0d, got kind=%0d cp=%h err=%0d",
                   e.kind, e.cp, e.err, kind, cp, err);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescape u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  unescape_scoreboard board;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  int beats_sent = 0;
  int cycles = 0;

  logic [CH_W-1:0] esc_set [8] = '{CH_BSLASH, CH_QUOTE, CH_SLASH, CH_LOW_B,
                                   CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("json_string_unescape verification failed");
      $finish;
    end
  end

  // Receiver: a long hold-off on request, else random stalls.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      board.check_result(out_if.kind, out_if.code_point, out_if.error_code);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic [CH_W-1:0] c, input logic eot);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ch <= c;
    in_if.end_of_text <= eot;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.note_input(c, eot);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(CH_W'(s[i]), 1'b0);
  endtask

  function automatic logic [CH_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 21'h30 + CH_W'(nib);
    return ($urandom_range(1) ? 21'h41 : 21'h61) + CH_W'(nib) - 21'd10;
  endfunction

  function automatic logic [CH_W-1:0] random_printable();
    if ($urandom_range(1)) return CH_W'($urandom_range(21'h20, 21'h7E));
    return CH_W'($urandom_range(21'h20, 21'h1FFFFF));
  endfunction

  function automatic bit is_hex(input logic [CH_W-1:0] c);
    return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h41 && c <= 21'h46) ||
           (c >= 21'h61 && c <= 21'h66);
  endfunction

  function automatic bit is_escape_letter(input logic [CH_W-1:0] c);
    foreach (esc_set[i]) if (esc_set[i] == c) return 1'b1;
    return c == CH_LOW_U;
  endfunction

  task automatic send_digits(input logic [HEX_W-1:0] v, input int count);
    for (int k = 3; k > 3 - count; k--) send_beat(hex_char(v[4*k +: 4]), 1'b0);
  endtask

  task automatic send_unicode(input logic [HEX_W-1:0] v);
    send_text("\\u");
    send_digits(v, 4);
  endtask

  function automatic logic [HEX_W-1:0] random_high();
    return HIGH_MIN + HEX_W'($urandom_range(10'h3FF));
  endfunction

  // Each token starts and ends with the decoder back at plain text.
  task automatic random_token();
    int pick;
    logic [CH_W-1:0] c;
    logic [HEX_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 38) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          c = CH_W'($urandom_range(21'h20, 21'h7E));
          if (c == CH_QUOTE || c == CH_BSLASH) c = 21'h41;
        end
        6, 7, 8: c = CH_W'($urandom_range(21'h80, 21'h1FFFFF));
        default: begin
          case ($urandom_range(3))
            0: c = 21'h1FFFFF;
            1: c = 21'h10FFFF;
            2: c = 21'h110000;
            default: c = 21'h20;
          endcase
        end
      endcase
      send_beat(c, 1'b0);
    end else if (pick < 53) begin
      send_beat(CH_BSLASH, 1'b0);
      send_beat(esc_set[$urandom_range(7)], 1'b0);
    end else if (pick < 63) begin
      v = HEX_W'($urandom());
      if (v >= HIGH_MIN && v <= HIGH_MAX) v = v ^ 16'h0800;
      // lone low surrogates pass through as plain values
      if ($urandom_range(3) == 0) v = LOW_BASE[HEX_W-1:0] + HEX_W'($urandom_range(10'h3FF));
      send_unicode(v);
    end else if (pick < 73) begin
      send_unicode(random_high());
      if ($urandom_range(4) == 0) v = HEX_W'($urandom());
      else v = LOW_BASE[HEX_W-1:0] + HEX_W'($urandom_range(10'h3FF));
      send_unicode(v);
    end else if (pick < 78) begin
      send_beat(CH_QUOTE, 1'b0);
    end else begin
      case ($urandom_range(8))
        0: begin  // text ends, possibly mid-escape
          case ($urandom_range(2))
            0: send_text("\\");
            1: send_text("\\u1");
            default: ;
          endcase
          send_beat(CH_W'($urandom_range(21'h1FFFFF)), 1'b1);
        end
        1: begin  // control character
          if ($urandom_range(1)) send_text("\\");
          send_beat(CH_W'($urandom_range(21'h1F)), 1'b0);
        end
        2: begin  // unknown escape
          do c = random_printable(); while (is_escape_letter(c));
          send_beat(CH_BSLASH, 1'b0);
          send_beat(c, 1'b0);
        end
        3, 4: begin  // bad digit or quote in the first group
          send_text("\\u");
          send_digits(HEX_W'($urandom()), $urandom_range(3));
          if (pick % 2 == 0) begin
            send_beat(CH_QUOTE, 1'b0);
          end else begin
            do c = random_printable(); while (is_hex(c) || c == CH_QUOTE);
            send_beat(c, 1'b0);
          end
        end
        5: begin  // high half not followed by a backslash
          send_unicode(random_high());
          do c = random_printable(); while (c == CH_BSLASH);
          send_beat(c, 1'b0);
        end
        6: begin  // backslash after the high half but no u
          send_unicode(random_high());
          send_beat(CH_BSLASH, 1'b0);
          do c = random_printable(); while (c == CH_LOW_U);
          send_beat(c, 1'b0);
        end
        default: begin  // low group cut by a quote or a bad digit
          send_unicode(random_high());
          send_text("\\u");
          send_digits(HEX_W'($urandom()), $urandom_range(3));
          if ($urandom_range(1)) begin
            send_beat(CH_QUOTE, 1'b0);
          end else begin
            do c = random_printable(); while (is_hex(c) || c == CH_QUOTE);
            send_beat(c, 1'b0);
          end
        end
      endcase
    end
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (board.expected_q.size() != 0);
  endtask

  initial begin
    int target;
    in_if.valid = 1'b0;
    in_if.ch = '0;
    in_if.end_of_text = 1'b0;
    out_if.ready = 1'b0;
    board = new();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    send_beat(21'h20, 1'b0);
    send_beat(21'h1FFFFF, 1'b0);
    send_beat(21'h1F, 1'b0);
    send_beat(21'h1FFFFF, 1'b1);
    send_text("\\q\\n\\uDbFf\\udC00\"\\u\"");
    wait_drain();

    target = beats_sent;
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          hold_request = 1'b1;
        end
        1: begin
          src_idle_pct = 79;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 79;
        end
        default: begin
          src_idle_pct = 28;
          sink_stall_pct = 28;
        end
      endcase
      target += BEATS_PER_MIX;
      while (beats_sent < target) random_token();
      wait_drain();
    end

    repeat (12) @(negedge clk_i);
    $display("covered %0d beats over four idle/stall mixes and a long output hold-off",
             board.beats);
    $display("results: %0d characters, %0d closes, %0d errors; error codes seen %b",
             board.chars, board.closes, board.faults, board.codes_seen[6:0]);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("json_string_unescape verification clean");
    end else begin
      $display("json_string_unescape verification failed");
    end
    $finish;
  end

endmodule
